### rtl/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg: shared types and constants for the relative range and bearing unit
// Field widths, the CORDIC angle table and the record that moves down the
// chain of cells.
// ----------------------------------------------------------------------------
package rrb_pkg;

   localparam int COORD_W   = 16;              // point and pose coordinates
   localparam int DIFF_W    = 17;              // point minus own position
   localparam int XY_W      = 28;              // CORDIC x/y, offset * 256 plus gain
   localparam int Z_W       = 26;              // angle in 1/65536 degree
   localparam int ANG_W     = 16;              // angle in 1/64 degree
   localparam int TURN_W    = 18;              // angle minus heading
   localparam int RED_W     = 20;              // candidates of the turn reduction
   localparam int SQ_W      = 33;              // dx*dx + dy*dy
   localparam int SQR_W     = 32;              // one square
   localparam int RES_W     = 34;              // square root working value
   localparam int RANGE_W   = 17;
   localparam int BEARING_W = 15;

   localparam int SQRT_STEPS = 17;             // one root bit per cell
   localparam int TABLE_LEN  = 24;
   localparam int ROUND_SH   = 10;             // 1/65536 degree to 1/64 degree

   localparam int HALF_TURN = 11520;
   localparam int FULL_TURN = 23040;
   localparam int RANGE_MAX = 92682;
   localparam int FINE_180  = 11796480;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_X       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_Y       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_HEADING = 2'd2;

   // round(atan(2^-i) in degrees * 65536)
   localparam logic [21:0] ATAN_TABLE [TABLE_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
      22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
      22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
   };

   function automatic logic [21:0] atan_at(input int idx);
      logic [21:0] val;
      val = '0;
      if (idx >= 0 && idx < TABLE_LEN) begin
         val = ATAN_TABLE[idx];
      end
      return val;
   endfunction

   typedef struct packed {
      logic                     zero;   // point coincides with the robot
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
      logic [SQ_W-1:0]          rem;    // square root remainder
      logic [RES_W-1:0]         res;    // square root partial result
   } rrb_lane_type;

endpackage

### rtl/rrb_front.sv
// ----------------------------------------------------------------------------
// rrb_front: offset, squares and CORDIC pre-rotation
// Three register stages that turn a point into the record entering the chain.
// ----------------------------------------------------------------------------
module rrb_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    take,
   input  logic signed [rrb_pkg::COORD_W-1:0]      point_x,
   input  logic signed [rrb_pkg::COORD_W-1:0]      point_y,
   input  logic signed [rrb_pkg::COORD_W-1:0]      own_x,
   input  logic signed [rrb_pkg::COORD_W-1:0]      own_y,
   output logic                                    vld_o,
   output rrb_pkg::rrb_lane_type                   lane_o
);
   import rrb_pkg::*;

   logic                      a_vld_ff, b_vld_ff, c_vld_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, dx_in, dy_in;
   logic [SQR_W-1:0]          sqx_ff, sqy_ff;
   logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
   logic                      zero_ff, zero_in;
   logic signed [XY_W-1:0]    x0_ff, y0_ff, x0_in, y0_in, dx_wide, dy_wide;
   logic signed [Z_W-1:0]     z0_ff, z0_in;
   rrb_lane_type              lane_ff, lane_in;

   assign dx_in = DIFF_W'(point_x) - DIFF_W'(own_x);
   assign dy_in = DIFF_W'(point_y) - DIFF_W'(own_y);

   always_comb begin
      sqx_full = dx_ff * dx_ff;
      sqy_full = dy_ff * dy_ff;
      dx_wide  = XY_W'(dx_ff) <<< 8;
      dy_wide  = XY_W'(dy_ff) <<< 8;
      zero_in  = (dx_ff == '0) && (dy_ff == '0);
      x0_in    = dx_wide;
      y0_in    = dy_wide;
      z0_in    = '0;
      // left half plane: turn the vector by half a turn first
      if (dx_ff < 0) begin
         x0_in = -dx_wide;
         y0_in = -dy_wide;
         z0_in = (dy_ff >= 0) ? Z_W'(FINE_180) : -Z_W'(FINE_180);
      end
   end

   always_comb begin
      lane_in      = '0;
      lane_in.zero = zero_ff;
      lane_in.x    = x0_ff;
      lane_in.y    = y0_ff;
      lane_in.z    = z0_ff;
      lane_in.rem  = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
      lane_in.res  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= take;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sqx_ff  <= sqx_full[SQR_W-1:0];
      sqy_ff  <= sqy_full[SQR_W-1:0];
      zero_ff <= zero_in;
      x0_ff   <= x0_in;
      y0_ff   <= y0_in;
      z0_ff   <= z0_in;
      lane_ff <= lane_in;
   end

   assign vld_o  = c_vld_ff;
   assign lane_o = lane_ff;

endmodule

### rtl/rrb_cell.sv
// ----------------------------------------------------------------------------
// rrb_cell: one cell of the chain
// CORDIC step if STEP < ROT_STEPS, root bit if STEP < SQRT_STEPS, then a register.
// ----------------------------------------------------------------------------
module rrb_cell #(
   parameter int STEP      = 0,
   parameter int ROT_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   vld_i,
   input  rrb_pkg::rrb_lane_type  lane_i,
   output logic                   vld_o,
   output rrb_pkg::rrb_lane_type  lane_o
);
   import rrb_pkg::*;

   localparam int ROT_SHIFT = (STEP < ROT_STEPS) ? STEP : 0;
   localparam int SQ_SHIFT  = (STEP < SQRT_STEPS) ? (2 * (SQRT_STEPS - 1 - STEP)) : 0;
   localparam logic [RES_W-1:0] SQ_BIT = RES_W'(1) << SQ_SHIFT;
   localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(atan_at(STEP));

   logic                    vld_ff;
   rrb_lane_type            lane_ff, lane_in;
   logic signed [XY_W-1:0]  x_cur, y_cur, x_sh, y_sh;
   logic [RES_W-1:0]        trial;

   always_comb begin
      x_cur   = lane_i.x;
      y_cur   = lane_i.y;
      x_sh    = x_cur >>> ROT_SHIFT;
      y_sh    = y_cur >>> ROT_SHIFT;
      trial   = lane_i.res + SQ_BIT;
      lane_in = lane_i;
      if (STEP < ROT_STEPS) begin
         if (y_cur > 0) begin
            lane_in.x = x_cur + y_sh;
            lane_in.y = y_cur - x_sh;
            lane_in.z = lane_i.z + ATAN_STEP;
         end else begin
            lane_in.x = x_cur - y_sh;
            lane_in.y = y_cur + x_sh;
            lane_in.z = lane_i.z - ATAN_STEP;
         end
      end
      if (STEP < SQRT_STEPS) begin
         if ({1'b0, lane_i.rem} >= trial) begin
            lane_in.rem = lane_i.rem - trial[SQ_W-1:0];
            lane_in.res = (lane_i.res >> 1) + SQ_BIT;
         end else begin
            lane_in.res = lane_i.res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign vld_o  = vld_ff;
   assign lane_o = lane_ff;

endmodule

### rtl/rrb_back.sv
// ----------------------------------------------------------------------------
// rrb_back: rounding, heading and turn reduction
// Rounds and clamps the root, rounds the angle, subtracts the heading and
// wraps the bearing into one turn and drives the result registers.
// ----------------------------------------------------------------------------
module rrb_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  vld_i,
   input  rrb_pkg::rrb_lane_type                 lane_i,
   input  logic signed [rrb_pkg::COORD_W-1:0]    own_heading,
   output logic                                  rsp_valid,
   output logic [rrb_pkg::RANGE_W-1:0]           rsp_range_out,
   output logic signed [rrb_pkg::BEARING_W-1:0]  rsp_bearing_out
);
   import rrb_pkg::*;

   logic                      d_vld_ff, rsp_valid_ff;
   logic                      zero_ff;
   logic signed [TURN_W-1:0]  turn_ff, turn_in;
   logic [RANGE_W-1:0]        range_ff, range_in, range_out_ff;
   logic signed [BEARING_W-1:0] bearing_out_ff, bearing_in;
   logic signed [Z_W-1:0]     z_rnd;
   logic signed [ANG_W-1:0]   ang;
   logic [RANGE_W:0]          root_rnd;
   logic signed [RED_W-1:0]   cand;

   always_comb begin
      z_rnd    = lane_i.z + Z_W'(512);
      ang      = z_rnd[Z_W-1:ROUND_SH];
      turn_in  = TURN_W'(ang) - TURN_W'(own_heading);
      // round to nearest: step up when the remainder passes the root
      root_rnd = {1'b0, lane_i.res[RANGE_W-1:0]}
               + (RANGE_W+1)'({1'b0, lane_i.rem} > lane_i.res);
      range_in = (root_rnd > (RANGE_W+1)'(RANGE_MAX)) ? RANGE_W'(RANGE_MAX)
                                                      : root_rnd[RANGE_W-1:0];
   end

   // exactly one shifted copy lands in (-half turn, half turn]
   always_comb begin
      bearing_in = '0;
      cand       = '0;
      for (int k = 0; k < 7; k++) begin
         cand = RED_W'(turn_ff) + RED_W'((k - 3) * FULL_TURN);
         if (cand > -HALF_TURN && cand <= HALF_TURN) begin
            bearing_in = cand[BEARING_W-1:0];
         end
      end
      if (zero_ff) begin
         bearing_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         d_vld_ff     <= vld_i;
         rsp_valid_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff        <= lane_i.zero;
      turn_ff        <= turn_in;
      range_ff       <= range_in;
      range_out_ff   <= range_ff;
      bearing_out_ff <= bearing_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_out   = range_out_ff;
   assign rsp_bearing_out = bearing_out_ff;

endmodule

### rtl/relative_range_bearing_unit.sv
// ----------------------------------------------------------------------------
// relative_range_bearing_unit: range and bearing of a point from the own pose
// Offsets a point by the robot position, takes its length by a bit-per-cell
// square root and its angle by CORDIC vectoring, and reports it in the robot
// frame.
// ----------------------------------------------------------------------------
// One item per cycle: start may be high in every cycle and busy is high only
// during reset. Each item gives one result on rsp_valid, in order, once it has
// passed the front stages, the chain of cells and the back stages; each cell
// does at most one CORDIC step and one root bit. There is no stall on the
// result side, so rsp_valid is a one-cycle strobe that must be captured when
// seen. Write the pose registers only while no item is in flight.
module relative_range_bearing_unit #(
   parameter int ITERATIONS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [rrb_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [rrb_pkg::COORD_W-1:0]    req_point_y,
   output logic                                  rsp_valid,
   output logic [rrb_pkg::RANGE_W-1:0]           rsp_range_out,
   output logic signed [rrb_pkg::BEARING_W-1:0]  rsp_bearing_out,
   input  logic                                  csr_we,
   input  logic [rrb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rrb_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import rrb_pkg::*;

   localparam int ROT_STEPS = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
   localparam int CHAIN_LEN = (ROT_STEPS > SQRT_STEPS) ? ROT_STEPS : SQRT_STEPS;

   logic signed [COORD_W-1:0] own_x_ff, own_y_ff, own_heading_ff;
   logic                      take;
   logic                      vld_w  [CHAIN_LEN+1];
   rrb_lane_type              lane_w [CHAIN_LEN+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff       <= '0;
         own_y_ff       <= '0;
         own_heading_ff <= '0;
      end else if (csr_we) begin
         priority if (csr_index == CSR_OWN_X) begin
            own_x_ff <= csr_wdata;
         end else if (csr_index == CSR_OWN_Y) begin
            own_y_ff <= csr_wdata;
         end else if (csr_index == CSR_OWN_HEADING) begin
            own_heading_ff <= csr_wdata;
         end else begin
            // drop writes to unused indexes
            own_x_ff <= own_x_ff;
         end
      end
   end

   assign busy = reset;
   assign take = start && !busy;

   rrb_front u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .point_x (req_point_x),
      .point_y (req_point_y),
      .own_x   (own_x_ff),
      .own_y   (own_y_ff),
      .vld_o   (vld_w[0]),
      .lane_o  (lane_w[0])
   );

   for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_cell
      rrb_cell #(
         .STEP      (g),
         .ROT_STEPS (ROT_STEPS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .vld_i  (vld_w[g]),
         .lane_i (lane_w[g]),
         .vld_o  (vld_w[g+1]),
         .lane_o (lane_w[g+1])
      );
   end

   rrb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .vld_i           (vld_w[CHAIN_LEN]),
      .lane_i          (lane_w[CHAIN_LEN]),
      .own_heading     (own_heading_ff),
      .rsp_valid       (rsp_valid),
      .rsp_range_out   (rsp_range_out),
      .rsp_bearing_out (rsp_bearing_out)
   );

endmodule
